@@ hdl/ltc_pkg.sv @@
// Shared types and constants for the tick-stamped LRU tag cache.
// No dependencies; imported by every module in hdl/.
package ltc_pkg;

   localparam int ENTRIES    = 4;
   localparam int TICK_WIDTH = 32;
   localparam int TAG_WIDTH  = 32;
   localparam int IDX_WIDTH  = $clog2(ENTRIES);

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   typedef logic [TAG_WIDTH-1:0]  tag_type;
   typedef logic [TICK_WIDTH-1:0] tick_type;
   typedef logic [IDX_WIDTH-1:0]  idx_type;

   typedef tag_type  [ENTRIES-1:0] tag_vec_type;
   typedef tick_type [ENTRIES-1:0] tick_vec_type;

   localparam tick_type TICK_ONE = tick_type'(1);

   typedef struct packed {
      logic        mode;
      logic [31:0] name_tag;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic        replaced_valid;
      logic [31:0] evicted_tag;
   } rsp_type;

   // State update produced by the lookup logic for one transfer
   typedef struct packed {
      logic     flush;
      logic     lookup;
      logic     wrap;
      tick_type tick;
      idx_type  idx;
      logic     fill;
      tag_type  tag;
   } upd_type;

endpackage

@@ hdl/ltc_store.sv @@
// Entry storage: tags, valid bits, stamps and the global tick.
// Depends on ltc_pkg.
module ltc_store
   import ltc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  upd_type      upd,
   output tag_vec_type  entry_tag,
   output logic [ENTRIES-1:0] entry_valid,
   output tick_vec_type entry_stamp,
   output tick_type     current_tick
);

   tag_vec_type        tag_ff;
   logic [ENTRIES-1:0] valid_ff;
   tick_vec_type       stamp_ff;
   tick_type           tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         valid_ff <= '0;
         stamp_ff <= '0;
         tick_ff  <= '0;
      end else if (upd.flush) begin
         // tick is kept across a flush
         tag_ff   <= '0;
         valid_ff <= '0;
         stamp_ff <= '0;
      end else if (upd.lookup) begin
         tick_ff <= upd.tick;
         // a wrap zeroes every stamp except the one being refreshed
         for (int i = 0; i < ENTRIES; i++) begin
            if (idx_type'(i) == upd.idx) begin
               stamp_ff[i] <= upd.tick;
            end else if (upd.wrap) begin
               stamp_ff[i] <= '0;
            end
         end
         if (upd.fill) begin
            tag_ff[upd.idx]   <= upd.tag;
            valid_ff[upd.idx] <= 1'b1;
         end
      end
   end

   assign entry_tag    = tag_ff;
   assign entry_valid  = valid_ff;
   assign entry_stamp  = stamp_ff;
   assign current_tick = tick_ff;

endmodule

@@ hdl/ltc_lookup.sv @@
// Lookup logic: tag match, tick advance and oldest-stamp victim select.
// Depends on ltc_pkg.
module ltc_lookup
   import ltc_pkg::*;
(
   input  logic               fire,
   input  req_type            req,
   input  tag_vec_type        entry_tag,
   input  logic [ENTRIES-1:0] entry_valid,
   input  tick_vec_type       entry_stamp,
   input  tick_type           current_tick,
   output rsp_type            rsp,
   output upd_type            upd
);

   tick_type tick_inc;
   tick_type tick_new;
   logic     wrap;
   tag_type  tag_in;
   logic     hit;
   idx_type  hit_idx;
   idx_type  victim;
   tick_type best;

   always_comb begin
      tag_in   = tag_type'(req.name_tag);
      tick_inc = tick_type'(current_tick + 1'b1);
      wrap     = (tick_inc == '0);
      tick_new = wrap ? TICK_ONE : tick_inc;

      // descending scan so the lowest matching index wins
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (entry_valid[i] && (entry_tag[i] == tag_in)) begin
            hit     = 1'b1;
            hit_idx = idx_type'(i);
         end
      end

      // strict less-than keeps the lowest index on ties; a wrap forces victim index 0
      best   = entry_stamp[0];
      victim = '0;
      for (int i = 1; i < ENTRIES; i++) begin
         if (entry_stamp[i] < best) begin
            best   = entry_stamp[i];
            victim = idx_type'(i);
         end
      end
      if (wrap) begin
         victim = '0;
      end

      rsp = '0;
      if (req.mode == MODE_LOOKUP) begin
         if (hit) begin
            rsp.hit = 1'b1;
            rsp.way = 2'(hit_idx);
         end else begin
            rsp.way            = 2'(victim);
            rsp.replaced_valid = entry_valid[victim];
            rsp.evicted_tag    = entry_valid[victim] ? 32'(entry_tag[victim]) : '0;
         end
      end

      upd.flush  = fire && (req.mode == MODE_FLUSH);
      upd.lookup = fire && (req.mode == MODE_LOOKUP);
      upd.wrap   = wrap;
      upd.tick   = tick_new;
      upd.idx    = hit ? hit_idx : victim;
      upd.fill   = !hit;
      upd.tag    = tag_in;
   end

endmodule

@@ hdl/lru_tag_cache_tick_stamped.sv @@
// Tick-stamped LRU tag cache, fully associative, top level.
// Output is registered: a request passes through the input register, then the result
// register, before rsp_valid rises.
// Throughput: one request per cycle unless rsp back-pressure stalls the result register;
// the lookup and entry update finish in the cycle the input register hands its item on.
// Reset: synchronous; clears all entries, valid bits, stamps, the tick and both valid flags.
// Depends on ltc_pkg, ltc_lookup and ltc_store.
module lru_tag_cache_tick_stamped
   import ltc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_type      in_data_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_type      out_data_ff;
   logic         fire;
   rsp_type      rsp_next;
   upd_type      upd;
   tag_vec_type  entry_tag;
   logic [ENTRIES-1:0] entry_valid;
   tick_vec_type entry_stamp;
   tick_type     current_tick;

   // held item moves to the result register when that register is free or drains
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= rsp_next;
      end
   end

   ltc_lookup u_lookup (
      .fire         (fire),
      .req          (in_data_ff),
      .entry_tag    (entry_tag),
      .entry_valid  (entry_valid),
      .entry_stamp  (entry_stamp),
      .current_tick (current_tick),
      .rsp          (rsp_next),
      .upd          (upd)
   );

   ltc_store u_store (
      .clock        (clock),
      .reset        (reset),
      .upd          (upd),
      .entry_tag    (entry_tag),
      .entry_valid  (entry_valid),
      .entry_stamp  (entry_stamp),
      .current_tick (current_tick)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ tb/lru_tag_cache_tick_stamped_tb.sv @@
// Self-checking testbench for lru_tag_cache_tick_stamped: directed and random lookups and
// flushes, checked against a tick-stamped LRU predictor kept in a scoreboard class.
// Depends on ltc_pkg and the lru_tag_cache_tick_stamped RTL.
module lru_tag_cache_tick_stamped_tb;
   import ltc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 200;
   localparam int POOL_SIZE    = 6;

   // Predicts each response from its own copy of tags, valid bits, stamps and the tick
   class tag_cache_scoreboard;
      tag_type  entry_tag   [ENTRIES];
      bit       entry_valid [ENTRIES];
      tick_type entry_stamp [ENTRIES];
      tick_type tick_now;
      rsp_type  expected_rsp [$];
      int       errors, lookups, hits, evictions, flushes, checked;

      function new();
         clear_entries();
         tick_now = '0;
      endfunction

      function void clear_entries();
         int i;
         for (i = 0; i < ENTRIES; i++) begin
            entry_tag[i]   = '0;
            entry_valid[i] = 1'b0;
            entry_stamp[i] = '0;
         end
      endfunction

      function void note_request(req_type r);
         rsp_type  e;
         tag_type  t;
         tick_type best;
         int       i, slot;
         e = '0;
         if (r.mode == MODE_FLUSH) begin
            clear_entries();
            flushes++;
         end else begin
            lookups++;
            t = tag_type'(r.name_tag);
            tick_now = tick_now + TICK_ONE;
            if (tick_now == '0) begin
               tick_now = TICK_ONE;
               for (i = 0; i < ENTRIES; i++) entry_stamp[i] = '0;
            end
            slot = -1;
            for (i = 0; i < ENTRIES; i++)
               if (slot < 0 && entry_valid[i] && entry_tag[i] == t) slot = i;
            if (slot >= 0) begin
               entry_stamp[slot] = tick_now;
               e.hit = 1'b1;
               e.way = 2'(slot);
               hits++;
            end else begin
               // victim: lowest index among the smallest stamps
               slot = 0;
               best = entry_stamp[0];
               for (i = 1; i < ENTRIES; i++) begin
                  if (entry_stamp[i] < best) begin
                     best = entry_stamp[i];
                     slot = i;
                  end
               end
               e.way = 2'(slot);
               if (entry_valid[slot]) begin
                  e.replaced_valid = 1'b1;
                  e.evicted_tag    = 32'(entry_tag[slot]);
                  evictions++;
               end
               entry_tag[slot]   = t;
               entry_valid[slot] = 1'b1;
               entry_stamp[slot] = tick_now;
            end
         end
         expected_rsp.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
         if (got_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
         end else begin
            e = expected_rsp.pop_front();
            checked++;
            compare_field("hit", 32'(e.hit), 32'(got.hit));
            compare_field("way", 32'(e.way), 32'(got.way));
            compare_field("replaced_valid", 32'(e.replaced_valid), 32'(got.replaced_valid));
            compare_field("evicted_tag", e.evicted_tag, got.evicted_tag);
         end
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   tag_cache_scoreboard sb = new();
   int          send_idle_pct = 17;
   int          recv_idle_pct = 57;
   int          cycle_count   = 0;
   int          hold_left     = 0;
   int          rsp_seen      = 0;
   int          longest_hold  = 0;
   logic [31:0] tag_pool [POOL_SIZE];

   lru_tag_cache_tick_stamped dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response side: check each transfer, then pick ready for the next cycle
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         sb.check_response(rsp_data);
         rsp_seen++;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (rsp_seen == 120 && longest_hold == 0) begin
         // long back-pressure so the cache fills and stalls its input
         rsp_ready    <= 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         longest_hold = HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic send_op(input logic mode, input logic [31:0] name_tag);
      req_type r;
      r.mode     = mode;
      r.name_tag = name_tag;
      send_request(r);
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_tag();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) return tag_pool[$urandom_range(POOL_SIZE - 1)];
      if (sel < 90) return $urandom;
      if (sel < 95) return 32'(1) << $urandom_range(31);
      return ~(32'(1) << $urandom_range(31));
   endfunction

   task automatic run_random(input int count);
      int k, i;
      for (k = 0; k < count; k++) begin
         if (k % 50 == 0)
            for (i = 0; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
         send_op(($urandom_range(99) < 4) ? MODE_FLUSH : MODE_LOOKUP, pick_tag());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero tag vs empty slots, fill order, hits, LRU eviction, flushes
      send_op(MODE_LOOKUP, 32'h0000_0000);
      send_op(MODE_LOOKUP, 32'hFFFF_FFFF);
      send_op(MODE_LOOKUP, 32'h0000_0000);
      send_op(MODE_LOOKUP, 32'h8000_0000);
      send_op(MODE_LOOKUP, 32'h0000_0001);
      send_op(MODE_LOOKUP, 32'h1234_5678);
      send_op(MODE_LOOKUP, 32'hFFFF_FFFF);
      send_op(MODE_LOOKUP, 32'h1234_5678);
      send_op(MODE_LOOKUP, 32'h0000_0001);
      send_op(MODE_LOOKUP, 32'h8000_0000);
      send_op(MODE_LOOKUP, 32'hFFFF_FFFF);
      send_op(MODE_LOOKUP, 32'h5555_AAAA);
      send_op(MODE_FLUSH,  32'hFFFF_FFFF);
      send_op(MODE_LOOKUP, 32'h1234_5678);
      send_op(MODE_FLUSH,  32'h0000_0000);
      send_op(MODE_FLUSH,  32'hA5A5_5A5A);
      send_op(MODE_LOOKUP, 32'h0000_0000);
      send_op(MODE_LOOKUP, 32'h0000_0000);
      send_op(MODE_LOOKUP, 32'h7FFF_FFFF);
      send_op(MODE_LOOKUP, 32'hAAAA_5555);
      send_op(MODE_LOOKUP, 32'hFFFF_FFFE);
      send_op(MODE_LOOKUP, 32'h0000_0000);
      send_op(MODE_LOOKUP, 32'hC0DE_0001);

      run_random(250);
      // sender pause until every response is back
      req_valid <= 1'b0;
      @(posedge clock);
      wait_drained();

      send_idle_pct = 57;
      recv_idle_pct = 17;
      run_random(250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(250);

      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Covered %0d lookups (%0d hits, %0d evictions) and %0d flushes; %0d responses checked.",
               sb.lookups, sb.hits, sb.evictions, sb.flushes, sb.checked);
      $display("Included a %0d-cycle response hold-off and a full drain between phases.",
               longest_hold);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ lru_tag_cache_tick_stamped.f @@
hdl/ltc_pkg.sv
hdl/ltc_store.sv
hdl/ltc_lookup.sv
hdl/lru_tag_cache_tick_stamped.sv
tb/lru_tag_cache_tick_stamped_tb.sv
